[hw/rtl/i2p_pkg.sv]
// shared types, constants and precedence functions for the infix to postfix converter
`timescale 1ns / 1ps

package i2p_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int PREC_W = 4;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_POW   = 8'h5E;
	localparam logic [7:0] CH_NOT   = 8'h7E;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNMATCHED = 2'd2;

	typedef enum logic [1:0] {
		CLS_OPERAND,
		CLS_OPER,
		CLS_CLOSE,
		CLS_FLUSH
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [7:0]        sym;
		logic [PREC_W-1:0] prec;
	} cmd_t;

	function automatic logic [PREC_W-1:0] prec_out(input logic [7:0] c);
		logic [PREC_W-1:0] p;
		p = '0;
		case (c) inside
			CH_PLUS, CH_MINUS: p = PREC_W'(1);
			CH_MUL, CH_DIV:    p = PREC_W'(3);
			CH_POW:            p = PREC_W'(6);
			CH_NOT:            p = PREC_W'(8);
			CH_OPEN:           p = PREC_W'(9);
			default:           p = '0;
		endcase
		return p;
	endfunction

	function automatic logic [PREC_W-1:0] prec_in(input logic [7:0] c);
		logic [PREC_W-1:0] p;
		p = '0;
		case (c) inside
			CH_PLUS, CH_MINUS: p = PREC_W'(2);
			CH_MUL, CH_DIV:    p = PREC_W'(4);
			CH_POW:            p = PREC_W'(5);
			CH_NOT:            p = PREC_W'(7);
			default:           p = '0;
		endcase
		return p;
	endfunction

endpackage

[hw/rtl/infix_to_postfix_converter.sv]
// top level of the infix to postfix converter
`timescale 1ns / 1ps

// Converts an infix expression, one byte per input item, to postfix order.
// Input channel: item_valid / item_stall with kind and symbol; kind 1 ends
// the expression and flushes the operator stack.
// Output channel: result_valid / result_stall with out_symbol, last, error;
// last marks the final result of an input item, error reports a dropped
// push on a full stack or an unmatched close parenthesis.
// A two-entry command queue parts the classifying front end from the stack
// engine, so items keep being accepted while the engine is busy.
// An accepted operand passes through the command queue and then the output
// register. In the engine, an operand, an unmatched close or an end item on
// an empty stack is handled in the idle state alone; any other item passes a
// read state and an evaluate state, and again for each further stack entry it
// pops, since the stack memory is read through a register. A stalled result
// makes the engine wait.
// Reset empties the queue, the stack and the output register at once.
// While result_stall is high the result holds; the engine waits, the queue
// fills and then item_stall rises.
module infix_to_postfix_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       kind,
	input  logic [7:0] symbol,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_symbol,
	output logic       last,
	output logic [1:0] error
);

	logic          q_full;
	logic          push;
	i2p_pkg::cmd_t push_cmd;
	logic          cmd_valid;
	logic          cmd_stall;
	i2p_pkg::cmd_t cmd;

	i2p_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.symbol     (symbol),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	i2p_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop_valid (cmd_valid),
		.pop_stall (cmd_stall),
		.pop_cmd   (cmd)
	);

	i2p_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (result_valid),
		.res_stall  (result_stall),
		.res_symbol (out_symbol),
		.res_last   (last),
		.res_error  (error)
	);

endmodule

[hw/rtl/i2p_front.sv]
// front end: accepts input items and classifies them into commands
`timescale 1ns / 1ps

module i2p_front (
	input  logic          item_valid,
	output logic          item_stall,
	input  logic          kind,
	input  logic [7:0]    symbol,
	input  logic          q_full,
	output logic          push,
	output i2p_pkg::cmd_t push_cmd
);

	i2p_pkg::cls_t cls;

	always_comb begin
		if (kind) begin
			cls = i2p_pkg::CLS_FLUSH;
		end else begin
			unique case (symbol) inside
				i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS, i2p_pkg::CH_MUL, i2p_pkg::CH_DIV,
				i2p_pkg::CH_POW, i2p_pkg::CH_NOT, i2p_pkg::CH_OPEN: cls = i2p_pkg::CLS_OPER;
				i2p_pkg::CH_CLOSE: cls = i2p_pkg::CLS_CLOSE;
				default:           cls = i2p_pkg::CLS_OPERAND;
			endcase
		end
	end

	assign push_cmd.cls  = cls;
	assign push_cmd.sym  = symbol;
	assign push_cmd.prec = i2p_pkg::prec_out(symbol);

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;

endmodule

[hw/rtl/i2p_queue.sv]
// short command queue between front and back
`timescale 1ns / 1ps

module i2p_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  i2p_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          pop_valid,
	input  logic          pop_stall,
	output i2p_pkg::cmd_t pop_cmd
);

	i2p_pkg::cmd_t                   entry_q [i2p_pkg::QUEUE_DEPTH];
	logic [i2p_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [i2p_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [i2p_pkg::QCNT_W-1:0]      fill_q;
	logic                            pop;

	assign full      = fill_q == i2p_pkg::QCNT_W'(i2p_pkg::QUEUE_DEPTH);
	assign pop_valid = fill_q != '0;
	assign pop       = pop_valid && !pop_stall;
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + i2p_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + i2p_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + i2p_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - i2p_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[hw/rtl/i2p_back.sv]
// back end: operator stack engine and result register
`timescale 1ns / 1ps

module i2p_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  i2p_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [7:0]    res_symbol,
	output logic          res_last,
	output logic [1:0]    res_error
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EVAL
	} state_t;

	localparam int CW = i2p_pkg::CNT_W;
	localparam int AW = i2p_pkg::ADDR_W;

	state_t           state_q;
	i2p_pkg::cmd_t    cur_q;
	logic [7:0]       top_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    open_q;
	logic             res_valid_q;
	logic [7:0]       res_symbol_q;
	logic             res_last_q;
	logic [1:0]       res_error_q;

	logic [7:0]       stack_mem [i2p_pkg::STACK_DEPTH];
	logic [7:0]       rd_q;
	logic [CW-1:0]    rd_cnt;
	logic [CW-1:0]    wr_cnt;
	logic             mem_we;

	logic             out_free;
	logic             idle_emit;
	logic             idle_go;
	logic             top_is_open;
	logic             more;
	logic             full_stack;
	logic [CW-1:0]    nonparen;
	logic             do_pop;
	logic             emit;
	logic [7:0]       e_sym;
	logic             e_last;
	logic [1:0]       e_err;
	logic             go;
	logic             res_load;

	assign out_free    = !res_valid_q || !res_stall;
	assign top_is_open = top_q == i2p_pkg::CH_OPEN;
	assign more        = cnt_q > CW'(1);
	assign full_stack  = cnt_q == CW'(i2p_pkg::STACK_DEPTH);
	assign nonparen    = cnt_q - open_q;
	assign rd_cnt      = cnt_q - CW'(2);
	assign wr_cnt      = cnt_q - CW'(1);

	assign idle_emit = (cmd.cls == i2p_pkg::CLS_OPERAND) ||
		(cmd.cls == i2p_pkg::CLS_CLOSE && open_q == '0);
	assign idle_go   = !idle_emit || out_free;
	assign cmd_stall = !(state_q == S_IDLE && idle_go);

	always_comb begin
		do_pop = 1'b0;
		emit   = 1'b0;
		e_sym  = top_q;
		e_last = 1'b0;
		e_err  = i2p_pkg::ERR_NONE;
		case (cur_q.cls)
			i2p_pkg::CLS_OPER: begin
				do_pop = (cnt_q != '0) && (cur_q.prec <= i2p_pkg::prec_in(top_q));
				if (do_pop) begin
					emit   = 1'b1;
					e_last = !more || (cur_q.prec > i2p_pkg::prec_in(rd_q));
				end else if (full_stack) begin
					emit   = 1'b1;
					e_sym  = '0;
					e_last = 1'b1;
					e_err  = i2p_pkg::ERR_OVERFLOW;
				end
			end
			i2p_pkg::CLS_CLOSE: begin
				do_pop = 1'b1;
				emit   = !top_is_open;
				e_last = rd_q == i2p_pkg::CH_OPEN;
			end
			i2p_pkg::CLS_FLUSH: begin
				do_pop = 1'b1;
				emit   = !top_is_open;
				e_last = nonparen == CW'(1);
			end
			default: begin
				do_pop = 1'b0;
			end
		endcase
	end

	assign go     = !emit || out_free;
	assign mem_we = state_q == S_EVAL && go && cur_q.cls == i2p_pkg::CLS_OPER &&
		!do_pop && cnt_q != '0 && !full_stack;

	// a new result enters the output register this cycle
	assign res_load = (state_q == S_IDLE && cmd_valid && idle_go && idle_emit) ||
		(state_q == S_EVAL && go && emit);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[wr_cnt[AW-1:0]] <= top_q;
		end
		rd_q <= stack_mem[rd_cnt[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			top_q        <= '0;
			cnt_q        <= '0;
			open_q       <= '0;
			res_valid_q  <= 1'b0;
			res_symbol_q <= '0;
			res_last_q   <= 1'b0;
			res_error_q  <= i2p_pkg::ERR_NONE;
		end else begin
			if (res_valid_q && !res_stall && !res_load) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && idle_go) begin
						if (cmd.cls == i2p_pkg::CLS_OPERAND) begin
							res_valid_q  <= 1'b1;
							res_symbol_q <= cmd.sym;
							res_last_q   <= 1'b1;
							res_error_q  <= i2p_pkg::ERR_NONE;
						end else if (cmd.cls == i2p_pkg::CLS_CLOSE && open_q == '0) begin
							res_valid_q  <= 1'b1;
							res_symbol_q <= '0;
							res_last_q   <= 1'b1;
							res_error_q  <= i2p_pkg::ERR_UNMATCHED;
						end else if (!(cmd.cls == i2p_pkg::CLS_FLUSH && cnt_q == '0)) begin
							cur_q   <= cmd;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (go) begin
						if (emit) begin
							res_valid_q  <= 1'b1;
							res_symbol_q <= e_sym;
							res_last_q   <= e_last;
							res_error_q  <= e_err;
						end
						case (cur_q.cls)
							i2p_pkg::CLS_OPER: begin
								if (do_pop && e_last) begin
									// pop and push in one step, depth unchanged
									top_q   <= cur_q.sym;
									state_q <= S_IDLE;
								end else if (do_pop) begin
									top_q   <= rd_q;
									cnt_q   <= cnt_q - CW'(1);
									state_q <= S_READ;
								end else begin
									if (!full_stack) begin
										top_q <= cur_q.sym;
										cnt_q <= cnt_q + CW'(1);
										if (cur_q.sym == i2p_pkg::CH_OPEN) begin
											open_q <= open_q + CW'(1);
										end
									end
									state_q <= S_IDLE;
								end
							end
							i2p_pkg::CLS_CLOSE: begin
								top_q <= rd_q;
								cnt_q <= cnt_q - CW'(1);
								if (top_is_open) begin
									open_q  <= open_q - CW'(1);
									state_q <= S_IDLE;
								end else begin
									state_q <= S_READ;
								end
							end
							i2p_pkg::CLS_FLUSH: begin
								top_q <= rd_q;
								cnt_q <= cnt_q - CW'(1);
								if (top_is_open) begin
									open_q <= open_q - CW'(1);
								end
								state_q <= more ? S_READ : S_IDLE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign res_symbol = res_symbol_q;
	assign res_last   = res_last_q;
	assign res_error  = res_error_q;

endmodule
